// File: hw/rtl/imrot_pkg.sv
// Shared types and constants for the nearest-neighbor frame rotator.
// No dependencies; every other file refers to it by scoped names.
package imrot_pkg;

   // fixed field widths
   localparam int COORD_W    = 8;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int DIM_W      = 9;
   localparam int TRIG_W     = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int REQ_DATA_W = 2 * COORD_W + PIX_W;

   // doubled center offset and its products with cos/sin
   localparam int OFS_W  = DIM_W + 2;
   localparam int PROD_W = OFS_W + TRIG_W;

   // response queue; holds every query that is in flight
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_PTR_W      = 3;
   localparam int RSP_CNT_W      = 4;

   // register reset values
   localparam logic signed [TRIG_W-1:0] COS_RESET    = 16'sd16384;
   localparam logic signed [TRIG_W-1:0] SIN_RESET    = 16'sd0;
   localparam logic [DIM_W-1:0]         WIDTH_RESET  = 9'd256;
   localparam logic [DIM_W-1:0]         HEIGHT_RESET = 9'd256;

   typedef enum logic {
      CMD_STORE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COS    = 2'd0,
      CSR_SIN    = 2'd1,
      CSR_WIDTH  = 2'd2,
      CSR_HEIGHT = 2'd3
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // per-beat control that rides along the pipeline
   typedef struct packed {
      logic valid;
      logic query;
      logic in_frame;
   } stage_ctrl_type;

endpackage

// File: hw/rtl/image_rotate_nearest_sample.sv
// A query passes the coordinate stages, the registered store read and the response
// queue. Throughput: one beat per clock while req_tready is high; the single-port
// frame store takes one access per cycle, and an 8-entry response queue with a credit
// count sets how many queries may be outstanding while rsp_tready is low.
// Reset: synchronous; clears pipeline valids, queue and the four registers.
// The frame store is not cleared; a pixel must be written before it is read.
module image_rotate_nearest_sample #(
   parameter int MAX_WIDTH      = 256,
   parameter int MAX_HEIGHT     = 256,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: col, row, in_blue, in_green, in_red (low to high)
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [imrot_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                  req_tuser,   // cmd
   // rsp_tdata: out_blue, out_green, out_red (low to high)
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [imrot_pkg::PIX_W-1:0]           rsp_tdata,
   output logic                                  rsp_tuser,   // from_source
   // register writes
   input  logic                                  csr_wr_en,
   input  logic [imrot_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [imrot_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int AW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int CNT_W = imrot_pkg::RSP_CNT_W;
   localparam int CW    = imrot_pkg::COORD_W;

   // configuration registers
   logic signed [imrot_pkg::TRIG_W-1:0] cos_ff, sin_ff;
   logic [imrot_pkg::DIM_W-1:0]         width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff    <= imrot_pkg::COS_RESET;
         sin_ff    <= imrot_pkg::SIN_RESET;
         width_ff  <= imrot_pkg::WIDTH_RESET;
         height_ff <= imrot_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (imrot_pkg::csr_index_type'(csr_index))
            imrot_pkg::CSR_COS:    cos_ff    <= $signed(csr_wr_data);
            imrot_pkg::CSR_SIN:    sin_ff    <= $signed(csr_wr_data);
            imrot_pkg::CSR_WIDTH:  width_ff  <= csr_wr_data[imrot_pkg::DIM_W-1:0];
            imrot_pkg::CSR_HEIGHT: height_ff <= csr_wr_data[imrot_pkg::DIM_W-1:0];
         endcase
      end
   end

   // input beat decode
   logic                 req_acc, req_query, rsp_acc;
   imrot_pkg::pixel_type req_pixel;

   assign req_acc   = req_tvalid && req_tready;
   assign req_query = (req_tuser == imrot_pkg::CMD_QUERY);
   assign req_pixel = req_tdata[imrot_pkg::REQ_DATA_W-1:2*CW];
   assign rsp_acc   = rsp_tvalid && rsp_tready;

   // credit count: queries accepted whose beat has not left yet
   logic [CNT_W-1:0] pending_ff, pending_in;
   logic             inc, dec;

   assign inc = req_acc && req_query;
   assign dec = rsp_acc;

   always_comb begin
      unique case ({inc, dec})
         2'b10:   pending_in = pending_ff + CNT_W'(1);
         2'b01:   pending_in = pending_ff - CNT_W'(1);
         default: pending_in = pending_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   assign req_tready = (pending_ff != CNT_W'(imrot_pkg::RSP_FIFO_DEPTH));

   // coordinate pipeline
   imrot_pkg::stage_ctrl_type mem_ctrl;
   logic [AW-1:0]             mem_addr;
   imrot_pkg::pixel_type      mem_wdata;

   imrot_coord #(
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_HEIGHT     (MAX_HEIGHT),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_coord (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_acc),
      .in_query     (req_query),
      .in_col       (req_tdata[CW-1:0]),
      .in_row       (req_tdata[2*CW-1:CW]),
      .in_pixel     (req_pixel),
      .cos_q14      (cos_ff),
      .sin_q14      (sin_ff),
      .image_width  (width_ff),
      .image_height (height_ff),
      .out_ctrl     (mem_ctrl),
      .out_addr     (mem_addr),
      .out_pixel    (mem_wdata)
   );

   // frame store: stores and queries hit it in beat order, so reads see
   // every earlier write without forwarding
   imrot_pkg::pixel_type rd_pixel;
   logic                 mem_we, mem_re;

   assign mem_we = mem_ctrl.valid && !mem_ctrl.query;
   assign mem_re = mem_ctrl.valid && mem_ctrl.query;

   imrot_frame_mem #(
      .DEPTH  (MAX_WIDTH * MAX_HEIGHT),
      .ADDR_W (AW)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (rd_pixel)
   );

   // read-data stage control
   logic s5_push_ff, s5_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_push_ff <= 1'b0;
      end else begin
         s5_push_ff <= mem_re;
      end
   end

   always_ff @(posedge clock) begin
      s5_inside_ff <= mem_ctrl.in_frame;
   end

   // response queue
   logic fifo_not_empty;

   imrot_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (s5_push_ff),
      .push_pixel  (rd_pixel),
      .push_inside (s5_inside_ff),
      .pop         (rsp_acc),
      .not_empty   (fifo_not_empty),
      .head_pixel  (rsp_tdata),
      .head_inside (rsp_tuser)
   );

   assign rsp_tvalid = fifo_not_empty;

   // checks
   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(imrot_pkg::RSP_FIFO_DEPTH))
      else $error("outstanding query count above queue depth");

   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != '0))
      else $error("response beat with no outstanding query");

   a_query_counted: assert property (@(posedge clock) disable iff (reset)
      (inc && !dec) |=> (pending_ff == $past(pending_ff) + CNT_W'(1)))
      else $error("accepted query not counted");

   a_push_has_credit: assert property (@(posedge clock) disable iff (reset)
      s5_push_ff |-> (pending_ff != '0))
      else $error("queue push without an outstanding query");

endmodule

// File: hw/rtl/imrot_coord.sv
// Coordinate pipeline: center offsets, rotation products, sums, floor and
// bounds check, and the frame store address for each beat. Uses imrot_pkg.
module imrot_coord #(
   parameter int MAX_WIDTH      = 256,
   parameter int MAX_HEIGHT     = 256,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic                                   in_query,
   input  logic [imrot_pkg::COORD_W-1:0]          in_col,
   input  logic [imrot_pkg::COORD_W-1:0]          in_row,
   input  imrot_pkg::pixel_type                   in_pixel,
   input  logic signed [imrot_pkg::TRIG_W-1:0]    cos_q14,
   input  logic signed [imrot_pkg::TRIG_W-1:0]    sin_q14,
   input  logic [imrot_pkg::DIM_W-1:0]            image_width,
   input  logic [imrot_pkg::DIM_W-1:0]            image_height,
   output imrot_pkg::stage_ctrl_type              out_ctrl,
   output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] out_addr,
   output imrot_pkg::pixel_type                   out_pixel
);

   localparam int AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int YW      = $clog2(MAX_HEIGHT);
   localparam int DW      = imrot_pkg::DIM_W;
   localparam int OW      = imrot_pkg::OFS_W;
   localparam int PW      = imrot_pkg::PROD_W;
   localparam int SUM_W   = ((TRIG_FRAC_BITS + 9 > 26) ? TRIG_FRAC_BITS + 9 : 26) + 2;
   localparam int FW      = SUM_W - TRIG_FRAC_BITS - 1;
   localparam int WLIM    = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
   localparam int HLIM    = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;
   localparam int NCOORD  = 2 ** imrot_pkg::COORD_W;

   // wrap tables for addressing the store: value modulo the store size
   logic [XW-1:0] col_mod [0:NCOORD-1];
   logic [YW-1:0] row_mod [0:NCOORD-1];

   for (genvar gi = 0; gi < NCOORD; gi++) begin : g_wrap
      assign col_mod[gi] = XW'(gi % MAX_WIDTH);
      assign row_mod[gi] = YW'(gi % MAX_HEIGHT);
   end

   // ---------------- stage 1: offsets and fallback address ----------------
   logic [DW-1:0]        wc_in, hc_in;
   logic signed [OW-1:0] dx2_in, dy2_in;
   logic [AW-1:0]        fb_addr_in;

   logic                  s1_valid_ff, s1_query_ff;
   logic [DW-1:0]         s1_wc_ff, s1_hc_ff;
   logic signed [OW-1:0]  s1_dx2_ff, s1_dy2_ff;
   logic [AW-1:0]         s1_fb_ff;
   imrot_pkg::pixel_type  s1_pix_ff;

   always_comb begin
      wc_in = (image_width > DW'(WLIM)) ? DW'(WLIM) : image_width;
      hc_in = (image_height > DW'(HLIM)) ? DW'(HLIM) : image_height;
      dx2_in = $signed({2'b00, in_col, 1'b0}) - $signed({2'b00, wc_in});
      dy2_in = $signed({2'b00, in_row, 1'b0}) - $signed({2'b00, hc_in});
      fb_addr_in = AW'(row_mod[in_row]) * AW'(MAX_WIDTH) + AW'(col_mod[in_col]);
   end

   // ---------------- stage 2: rotation products ----------------
   logic signed [PW-1:0] p_xc_in, p_ys_in, p_yc_in, p_xs_in;

   logic                  s2_valid_ff, s2_query_ff;
   logic [DW-1:0]         s2_wc_ff, s2_hc_ff;
   logic signed [PW-1:0]  s2_p_xc_ff, s2_p_ys_ff, s2_p_yc_ff, s2_p_xs_ff;
   logic [AW-1:0]         s2_fb_ff;
   imrot_pkg::pixel_type  s2_pix_ff;

   always_comb begin
      p_xc_in = PW'(s1_dx2_ff) * PW'(cos_q14);
      p_ys_in = PW'(s1_dy2_ff) * PW'(sin_q14);
      p_yc_in = PW'(s1_dy2_ff) * PW'(cos_q14);
      p_xs_in = PW'(s1_dx2_ff) * PW'(sin_q14);
   end

   // ---------------- stage 3: sums plus center ----------------
   logic signed [SUM_W-1:0] xs_in, ys_in;

   logic                    s3_valid_ff, s3_query_ff;
   logic [DW-1:0]           s3_wc_ff, s3_hc_ff;
   logic signed [SUM_W-1:0] s3_xs_ff, s3_ys_ff;
   logic [AW-1:0]           s3_fb_ff;
   imrot_pkg::pixel_type    s3_pix_ff;

   always_comb begin
      xs_in = SUM_W'(s2_p_xc_ff) + SUM_W'(s2_p_ys_ff)
            + $signed(SUM_W'(s2_wc_ff) << TRIG_FRAC_BITS);
      ys_in = SUM_W'(s2_p_yc_ff) - SUM_W'(s2_p_xs_ff)
            + $signed(SUM_W'(s2_hc_ff) << TRIG_FRAC_BITS);
   end

   // ---------------- stage 4: floor, bounds, address select ----------------
   logic [FW-1:0] fx, fy;
   logic          inside_in;
   logic [AW-1:0] src_addr, addr_in;

   logic                  s4_valid_ff, s4_query_ff, s4_inside_ff;
   logic [AW-1:0]         s4_addr_ff;
   imrot_pkg::pixel_type  s4_pix_ff;

   always_comb begin
      fx = s3_xs_ff[SUM_W-1:TRIG_FRAC_BITS+1];
      fy = s3_ys_ff[SUM_W-1:TRIG_FRAC_BITS+1];
      inside_in = !s3_xs_ff[SUM_W-1] && !s3_ys_ff[SUM_W-1]
                  && (fx < FW'(s3_wc_ff)) && (fy < FW'(s3_hc_ff));
      src_addr = AW'(fy) * AW'(MAX_WIDTH) + AW'(fx);
      addr_in = (s3_query_ff && inside_in) ? src_addr : s3_fb_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_query_ff  <= in_query;
      s1_wc_ff     <= wc_in;
      s1_hc_ff     <= hc_in;
      s1_dx2_ff    <= dx2_in;
      s1_dy2_ff    <= dy2_in;
      s1_fb_ff     <= fb_addr_in;
      s1_pix_ff    <= in_pixel;

      s2_query_ff  <= s1_query_ff;
      s2_wc_ff     <= s1_wc_ff;
      s2_hc_ff     <= s1_hc_ff;
      s2_p_xc_ff   <= p_xc_in;
      s2_p_ys_ff   <= p_ys_in;
      s2_p_yc_ff   <= p_yc_in;
      s2_p_xs_ff   <= p_xs_in;
      s2_fb_ff     <= s1_fb_ff;
      s2_pix_ff    <= s1_pix_ff;

      s3_query_ff  <= s2_query_ff;
      s3_wc_ff     <= s2_wc_ff;
      s3_hc_ff     <= s2_hc_ff;
      s3_xs_ff     <= xs_in;
      s3_ys_ff     <= ys_in;
      s3_fb_ff     <= s2_fb_ff;
      s3_pix_ff    <= s2_pix_ff;

      s4_query_ff  <= s3_query_ff;
      s4_inside_ff <= inside_in;
      s4_addr_ff   <= addr_in;
      s4_pix_ff    <= s3_pix_ff;
   end

   assign out_ctrl.valid    = s4_valid_ff;
   assign out_ctrl.query    = s4_query_ff;
   assign out_ctrl.in_frame = s4_inside_ff;
   assign out_addr          = s4_addr_ff;
   assign out_pixel         = s4_pix_ff;

endmodule

// File: hw/rtl/imrot_frame_mem.sv
// Single-port frame store, one access per cycle, registered read data.
// Write and read share the address; uses imrot_pkg for the pixel type.
module imrot_frame_mem #(
   parameter int DEPTH  = 65536,
   parameter int ADDR_W = 16
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    addr,
   input  imrot_pkg::pixel_type wr_data,
   output imrot_pkg::pixel_type rd_data
);

   imrot_pkg::pixel_type store_ff [0:DEPTH-1];
   imrot_pkg::pixel_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/imrot_rsp_fifo.sv
// Response queue between the frame store read and the rsp_ channel.
// Sized by imrot_pkg::RSP_FIFO_DEPTH; the top level never overfills it.
module imrot_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  imrot_pkg::pixel_type push_pixel,
   input  logic                 push_inside,
   input  logic                 pop,
   output logic                 not_empty,
   output imrot_pkg::pixel_type head_pixel,
   output logic                 head_inside
);

   localparam int DEPTH = imrot_pkg::RSP_FIFO_DEPTH;
   localparam int PTR_W = imrot_pkg::RSP_PTR_W;
   localparam int CNT_W = imrot_pkg::RSP_CNT_W;

   logic [imrot_pkg::PIX_W:0] entry_ff [0:DEPTH-1];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {push_inside, push_pixel};
      end
   end

   assign not_empty   = (count_ff != '0);
   assign head_pixel  = entry_ff[rd_ptr_ff][imrot_pkg::PIX_W-1:0];
   assign head_inside = entry_ff[rd_ptr_ff][imrot_pkg::PIX_W];

endmodule

// File: bench/rotate_checker.sv
// Watches the request, response and register channels of the frame rotator.
// It predicts each query's output pixel and compares it with the response beat.
// Depends on imrot_pkg for the command and register index codes and widths.
`timescale 1ns / 1ps

module rotate_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [imrot_pkg::REQ_DATA_W-1:0]  req_tdata,   // col, row, blue, green, red
   input  logic                              req_tuser,   // cmd
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [imrot_pkg::PIX_W-1:0]       rsp_tdata,   // blue, green, red
   input  logic                              rsp_tuser,   // from_source
   input  logic                              csr_wr_en,
   input  logic [imrot_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [imrot_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                                mismatches,
   output int                                pending
);

   localparam int FRAME_SIDE = 256;
   localparam int FRAC_BITS  = 14;
   localparam int CW         = imrot_pkg::CHAN_W;
   localparam int KW         = imrot_pkg::COORD_W;

   typedef struct packed {
      logic [CW-1:0] blue;
      logic [CW-1:0] green;
      logic [CW-1:0] red;
      logic          from_source;
   } out_pixel_type;

   // shadow of the frame store and of the four registers
   imrot_pkg::pixel_type                frame_copy [0:FRAME_SIDE*FRAME_SIDE-1];
   logic signed [imrot_pkg::TRIG_W-1:0] cos_r    = imrot_pkg::COS_RESET;
   logic signed [imrot_pkg::TRIG_W-1:0] sin_r    = imrot_pkg::SIN_RESET;
   logic [imrot_pkg::DIM_W-1:0]         width_r  = imrot_pkg::WIDTH_RESET;
   logic [imrot_pkg::DIM_W-1:0]         height_r = imrot_pkg::HEIGHT_RESET;

   out_pixel_type awaited_pixels [$];
   int            mismatch_count = 0;

   // rotate (col,row) about the frame center, floor, pick source or fallback pixel
   function automatic out_pixel_type rotate_lookup(logic [KW-1:0] col,
                                                   logic [KW-1:0] row);
      longint               w, h, dx2, dy2, xs, ys;
      logic                 in_frame;
      imrot_pkg::pixel_type pix;
      out_pixel_type        res;
      w   = (width_r  > 9'd256) ? 256 : longint'(width_r);
      h   = (height_r > 9'd256) ? 256 : longint'(height_r);
      dx2 = 2 * longint'(col) - w;
      dy2 = 2 * longint'(row) - h;
      xs  = dx2 * longint'(cos_r) + dy2 * longint'(sin_r) + (w <<< FRAC_BITS);
      ys  = dy2 * longint'(cos_r) - dx2 * longint'(sin_r) + (h <<< FRAC_BITS);
      in_frame = (xs >= 0) && ((xs >>> (FRAC_BITS + 1)) < w) &&
                 (ys >= 0) && ((ys >>> (FRAC_BITS + 1)) < h);
      if (in_frame) begin
         pix = frame_copy[int'(ys >>> (FRAC_BITS + 1)) * FRAME_SIDE +
                          int'(xs >>> (FRAC_BITS + 1))];
      end else begin
         pix = frame_copy[{row, col}];
      end
      res.blue        = pix[CW-1:0];
      res.green       = pix[2*CW-1:CW];
      res.red         = pix[3*CW-1:2*CW];
      res.from_source = in_frame;
      return res;
   endfunction

   function automatic void compare_field(string label, int want_v, int got_v);
      if (want_v != got_v) begin
         $display("%0t ns: %s expected %0d actual %0d", $time, label, want_v, got_v);
         mismatch_count++;
      end
   endfunction

   // per-edge bookkeeping: responses first, then registers, then requests
   always @(posedge clock) begin : watch
      out_pixel_type got;
      out_pixel_type want;
      if (reset) begin
         cos_r    = imrot_pkg::COS_RESET;
         sin_r    = imrot_pkg::SIN_RESET;
         width_r  = imrot_pkg::WIDTH_RESET;
         height_r = imrot_pkg::HEIGHT_RESET;
         awaited_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[CW-1:0], rsp_tdata[2*CW-1:CW],
                   rsp_tdata[3*CW-1:2*CW], rsp_tuser};
            if (awaited_pixels.size() == 0) begin
               $display("%0t ns: response beat with none expected, actual %h/%b",
                        $time, rsp_tdata, rsp_tuser);
               mismatch_count++;
            end else begin
               want = awaited_pixels.pop_front();
               compare_field("blue", want.blue, got.blue);
               compare_field("green", want.green, got.green);
               compare_field("red", want.red, got.red);
               compare_field("from_source", want.from_source, got.from_source);
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               imrot_pkg::CSR_COS:    cos_r    = csr_wr_data;
               imrot_pkg::CSR_SIN:    sin_r    = csr_wr_data;
               imrot_pkg::CSR_WIDTH:  width_r  = csr_wr_data[imrot_pkg::DIM_W-1:0];
               imrot_pkg::CSR_HEIGHT: height_r = csr_wr_data[imrot_pkg::DIM_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == imrot_pkg::CMD_STORE) begin
               frame_copy[req_tdata[2*KW-1:0]] =
                  req_tdata[imrot_pkg::REQ_DATA_W-1:2*KW];
            end else begin
               awaited_pixels.push_back(rotate_lookup(req_tdata[KW-1:0],
                                                      req_tdata[2*KW-1:KW]));
            end
         end
      end
      pending    <= awaited_pixels.size();
      mismatches <= mismatch_count;
   end

endmodule

// File: bench/tb.sv
// Top of the frame rotator bench: clock, reset, register writes and beat stimulus.
// Depends on imrot_pkg, image_rotate_nearest_sample and rotate_checker.
`timescale 1ns / 1ps

module tb;

   localparam int LIMIT     = 1_000_000;
   localparam int IDLE_PCT  = 28;
   localparam int SETTLE    = 12;
   localparam int PHASES    = 10;
   localparam int PER_PHASE = 130;
   localparam int QUIET_PHASE = 4;
   localparam int KW        = imrot_pkg::COORD_W;

   logic                                 clock = 1'b0;
   logic                                 reset;
   logic                                 req_tvalid;
   logic                                 req_tready;
   logic [imrot_pkg::REQ_DATA_W-1:0]     req_tdata;
   logic                                 req_tuser;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [imrot_pkg::PIX_W-1:0]          rsp_tdata;
   logic                                 rsp_tuser;
   logic                                 csr_wr_en;
   logic [imrot_pkg::CSR_IDX_W-1:0]      csr_index;
   logic [imrot_pkg::CSR_DATA_W-1:0]     csr_wr_data;

   int   mismatches;
   int   pending;
   int   cycle_count = 0;
   logic quiet = 1'b0;
   int   cur_w = 256;
   int   cur_h = 256;
   int   cur_cos = 16384;
   int   cur_sin = 0;

   // store entries already written by a store beat
   bit   written [0:65535];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   image_rotate_nearest_sample DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rotate_checker watch (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // one request beat, with a random gap ahead of it; returns on the accepting edge
   task automatic send_beat(imrot_pkg::cmd_type cmd, logic [KW-1:0] col,
                            logic [KW-1:0] row, imrot_pkg::pixel_type pix);
      while (!quiet && ($urandom_range(99) < IDLE_PCT)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      if (cmd == imrot_pkg::CMD_STORE) written[{row, col}] = 1'b1;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {pix, row, col};
      do @(posedge clock); while (!req_tready);
   endtask

   // store entry that a query at (col,row) reads under the current registers
   function automatic int read_addr(logic [KW-1:0] col, logic [KW-1:0] row);
      longint dx2, dy2, xs, ys, fx, fy;
      dx2 = 2 * longint'(col) - longint'(cur_w);
      dy2 = 2 * longint'(row) - longint'(cur_h);
      xs  = dx2 * cur_cos + dy2 * cur_sin + (longint'(cur_w) <<< 14);
      ys  = dy2 * cur_cos - dx2 * cur_sin + (longint'(cur_h) <<< 14);
      fx  = xs >>> 15;
      fy  = ys >>> 15;
      if (xs >= 0 && fx < cur_w && ys >= 0 && fy < cur_h) begin
         return int'(fy) * 256 + int'(fx);
      end
      return int'(row) * 256 + int'(col);
   endfunction

   // query beat; writes the entry it will read first if that entry is still blank
   task automatic query_beat(logic [KW-1:0] col, logic [KW-1:0] row);
      int a;
      a = read_addr(col, row);
      if (!written[a]) begin
         send_beat(imrot_pkg::CMD_STORE, KW'(a), KW'(a >> 8),
                   imrot_pkg::pixel_type'($urandom));
      end
      send_beat(imrot_pkg::CMD_QUERY, col, row, '0);
   endtask

   // stop sending until every query has been answered and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // all four registers back to back
   task automatic write_regs(logic [15:0] cos_v, logic [15:0] sin_v,
                             logic [8:0] w, logic [8:0] h);
      imrot_pkg::csr_index_type             regs [4];
      logic [imrot_pkg::CSR_DATA_W-1:0]     vals [4];
      regs = '{imrot_pkg::CSR_COS, imrot_pkg::CSR_SIN,
               imrot_pkg::CSR_WIDTH, imrot_pkg::CSR_HEIGHT};
      vals = '{cos_v, sin_v, {7'd0, w}, {7'd0, h}};
      for (int i = 0; i < 4; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= regs[i];
         csr_wr_data <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cur_w   = (w > 9'd256) ? 256 : int'(w);
      cur_h   = (h > 9'd256) ? 256 : int'(h);
      cur_cos = int'($signed(cos_v));
      cur_sin = int'($signed(sin_v));
   endtask

   function automatic logic [15:0] pick_trig();
      logic [15:0] corner [5];
      corner = '{16'h8000, 16'hC000, 16'h0000, 16'h4000, 16'h7FFF};
      case ($urandom_range(3))
         0:       return corner[$urandom_range(4)];
         3:       return 16'($urandom_range(65535));
         default: return 16'($urandom_range(32768) - 16384);
      endcase
   endfunction

   function automatic logic [8:0] pick_dim();
      case ($urandom_range(9))
         0:       return 9'd0;
         1:       return 9'($urandom_range(257, 511));
         2:       return 9'd256;
         3:       return 9'd1;
         default: return 9'($urandom_range(1, 256));
      endcase
   endfunction

   // mostly in-frame positions, sometimes anywhere in the store
   function automatic logic [KW-1:0] pick_coord(int lim);
      if (lim > 0 && $urandom_range(9) < 8) return KW'($urandom_range(lim - 1));
      return KW'($urandom_range(255));
   endfunction

   initial begin
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= imrot_pkg::CMD_STORE;
      csr_wr_en   <= 1'b0;
      csr_index   <= imrot_pkg::CSR_COS;
      csr_wr_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values: identity rotation over the full frame, corner pixels
      query_beat(8'd0, 8'd0);
      query_beat(8'd255, 8'd255);
      send_beat(imrot_pkg::CMD_STORE, 8'd0, 8'd0, 24'h000000);
      send_beat(imrot_pkg::CMD_STORE, 8'd255, 8'd255, 24'hFFFFFF);
      query_beat(8'd0, 8'd0);
      query_beat(8'd255, 8'd255);
      query_beat(8'd255, 8'd0);
      settle();

      // quarter turn
      write_regs(16'h0000, 16'h4000, 9'd256, 9'd256);
      query_beat(8'd0, 8'd0);
      query_beat(8'd128, 8'd128);
      query_beat(8'd255, 8'd0);
      settle();

      // half turn on a single pixel frame, plus a query outside the frame
      write_regs(16'hC000, 16'h0000, 9'd1, 9'd1);
      query_beat(8'd0, 8'd0);
      query_beat(8'd5, 8'd7);
      settle();

      // zero size: never from source
      write_regs(16'h8000, 16'h7FFF, 9'd0, 9'd0);
      query_beat(8'd3, 8'd3);
      settle();

      // oversized frame clamps to the store size
      write_regs(16'h7FFF, 16'h8000, 9'd511, 9'd300);
      query_beat(8'd0, 8'd0);
      query_beat(8'd255, 8'd255);
      query_beat(8'd17, 8'd200);
      settle();

      // negative cos and sin on a narrow frame
      write_regs(16'hC000, 16'hC000, 9'd2, 9'd255);
      query_beat(8'd1, 8'd254);
      query_beat(8'd0, 8'd0);
      settle();

      // random phases, each with its own register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         write_regs(pick_trig(), pick_trig(), pick_dim(), pick_dim());
         quiet = (ph == QUIET_PHASE);
         for (int n = 0; n < PER_PHASE; n++) begin
            if ($urandom_range(9) < 6) begin
               query_beat(pick_coord(cur_w), pick_coord(cur_h));
            end else begin
               send_beat(imrot_pkg::CMD_STORE, pick_coord(cur_w), pick_coord(cur_h),
                         imrot_pkg::pixel_type'($urandom));
            end
            if ($urandom_range(299) == 0) settle();
         end
         quiet = 1'b0;
         settle();
      end

      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
